[rtl/core/assert_macros.svh]
// Assertion macros used by dag_critical_path.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define DCP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define DCP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/dcp_pkg.sv]
// Package: sizes, sequencer state codes and shared-unit types for the critical path block.
package dcp_pkg;

    localparam int MAX_V  = 32;
    localparam int MAX_E  = 32;
    localparam int VW     = 5;   // vertex index bits
    localparam int CW     = 6;   // count bits (holds MAX_V / MAX_E)
    localparam int WB     = 16;  // weight bits
    localparam int TW     = 21;  // event time bits

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEG   = 4'd1;
    localparam logic [3:0] S_SEED  = 4'd2;
    localparam logic [3:0] S_POP   = 4'd3;
    localparam logic [3:0] S_RELAX = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_MAX   = 4'd6;
    localparam logic [3:0] S_BPOP  = 4'd7;
    localparam logic [3:0] S_BEDGE = 4'd8;
    localparam logic [3:0] S_CRIT  = 4'd9;
    localparam logic [3:0] S_SUM   = 4'd10;

    // Input commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    typedef struct packed {
        logic          sub;
        logic [TW-1:0] a;
        logic [TW-1:0] b;
        logic [TW-1:0] c;
    } t_alu_req;

    typedef struct packed {
        logic [TW:0] res;
        logic        gt;
        logic        lt;
        logic        eq;
    } t_alu_rsp;

endpackage

[rtl/core/dcp_ifs.sv]
// Stream interfaces: edge/command beats in, result beats out.
interface dcp_item_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [4:0]  src_vertex;
    logic [4:0]  dst_vertex;
    logic [15:0] weight;
    modport source(output valid, cmd, src_vertex, dst_vertex, weight, input ready);
    modport sink(input valid, cmd, src_vertex, dst_vertex, weight, output ready);
endinterface

interface dcp_result_if;
    logic        valid;
    logic        ready;
    logic        is_edge;
    logic [4:0]  edge_from;
    logic [4:0]  edge_to;
    logic [20:0] path_length;
    logic        cyclic;
    logic        overflow;
    logic        last;
    modport source(output valid, is_edge, edge_from, edge_to, path_length, cyclic,
                   overflow, last, input ready);
    modport sink(input valid, is_edge, edge_from, edge_to, path_length, cyclic,
                 overflow, last, output ready);
endinterface

[rtl/core/dcp_alu.sv]
// Shared add/subtract and compare unit used by the relax, maximum, backward and edge-scan phases.
module dcp_alu (
    input  dcp_pkg::t_alu_req i_req,
    output dcp_pkg::t_alu_rsp o_rsp
);
    import dcp_pkg::*;

    logic [TW:0] sum;
    logic [TW:0] cmp;

    // a +/- b, then compare against c
    assign sum = i_req.sub ? ({1'b0, i_req.a} - {1'b0, i_req.b})
                           : ({1'b0, i_req.a} + {1'b0, i_req.b});
    assign cmp = {1'b0, i_req.c};

    assign o_rsp.res = sum;
    assign o_rsp.gt  = sum > cmp;
    assign o_rsp.lt  = sum < cmp;
    assign o_rsp.eq  = sum == cmp;

endmodule

[rtl/core/dag_critical_path.sv]
// Critical path analyzer for an activity-on-edge graph, top level.
// A load beat (cmd 0) stores one weighted edge and returns no result; edges past
// the 32-entry store or naming a vertex at or above vertex_count are dropped and flagged.
// A run beat (cmd 1) is worked by one sequencer that drives a single add/compare unit, one
// edge or one vertex per cycle while the output is not stalled: in-degree count, seeding,
// forward sort and earliest times, maximum, backward latest times and the critical edge scan.
// The block takes no beat during a run. It emits each critical edge (none for a cyclic graph),
// then a summary beat with last set, and empties the edge store.
`include "assert_macros.svh"

module dag_critical_path (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [5:0]           i_cfg_wdata,
    dcp_item_if.sink             i_item,
    dcp_result_if.source         o_result
);
    import dcp_pkg::*;

    // Control registers
    logic [3:0]    r_state;
    logic [CW-1:0] r_vc;
    logic [CW-1:0] r_etot;
    logic          r_drop;
    logic [CW-1:0] r_k;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_head;
    logic [CW-1:0] r_tail;
    logic [CW-1:0] r_i;
    logic [VW-1:0] r_vx;
    logic [TW-1:0] r_eu;
    logic [TW-1:0] r_lu;
    logic [TW-1:0] r_len;
    logic          r_cyc;

    // Stores
    logic [VW-1:0] r_esrc [MAX_E];
    logic [VW-1:0] r_edst [MAX_E];
    logic [WB-1:0] r_ew   [MAX_E];
    logic [CW-1:0] r_indeg [MAX_V];
    logic [TW-1:0] r_earl  [MAX_V];
    logic [TW-1:0] r_late  [MAX_V];
    logic [VW-1:0] r_topo  [MAX_V];

    // Output register
    logic          r_ovalid;
    logic          r_oedge;
    logic [VW-1:0] r_ofrom;
    logic [VW-1:0] r_oto;
    logic [TW-1:0] r_olen;
    logic          r_ocyc;
    logic          r_oovf;
    logic          r_olast;

    logic [CW-1:0] w_n;
    logic [VW-1:0] e_src;
    logic [VW-1:0] e_dst;
    logic [TW-1:0] e_w;
    logic          e_end;
    logic          v_ok;
    logic          out_free;
    logic          w_crit_hit;
    logic          w_emit;
    logic [VW-1:0] topo_back;
    t_alu_req      alu_req;
    t_alu_rsp      alu_rsp;

    // Effective vertex count: 0 acts as 1, above MAX_V acts as MAX_V
    always_comb begin
        if (r_vc == '0) begin
            w_n = CW'(1);
        end else if (r_vc > CW'(MAX_V)) begin
            w_n = CW'(MAX_V);
        end else begin
            w_n = r_vc;
        end
    end

    // Current edge
    assign e_src     = r_esrc[r_k[VW-1:0]];
    assign e_dst     = r_edst[r_k[VW-1:0]];
    assign e_w       = {{(TW-WB){1'b0}}, r_ew[r_k[VW-1:0]]};
    assign e_end     = (r_k == r_etot);
    assign v_ok      = {1'b0, e_dst} < w_n;
    assign out_free  = !r_ovalid || o_result.ready;
    assign topo_back = r_topo[VW'(r_i - CW'(1))];

    // Result beat loaded this cycle: a zero-slack edge or the summary
    assign w_crit_hit = (r_state == S_CRIT) && (r_cnt != w_n) && !e_end &&
                        (e_src == r_cnt[VW-1:0]) && v_ok && alu_rsp.eq;
    assign w_emit     = out_free && (w_crit_hit || (r_state == S_SUM));

    // Operand select for the shared unit
    always_comb begin
        case (r_state)
            S_RELAX: begin
                alu_req = '{sub: 1'b0, a: r_eu, b: e_w, c: r_earl[e_dst]};
            end
            S_BEDGE: begin
                alu_req = '{sub: 1'b1, a: r_late[e_dst], b: e_w, c: r_lu};
            end
            S_CRIT: begin
                alu_req = '{sub: 1'b1, a: r_late[e_dst], b: e_w, c: r_earl[r_cnt[VW-1:0]]};
            end
            default: begin
                alu_req = '{sub: 1'b0, a: r_earl[r_cnt[VW-1:0]], b: '0, c: r_len};
            end
        endcase
    end

    dcp_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign i_item.ready = (r_state == S_IDLE);

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vc     <= CW'(MAX_V);
            r_etot   <= '0;
            r_drop   <= 1'b0;
            r_ovalid <= 1'b0;
            r_k      <= '0;
            r_cnt    <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_i      <= '0;
            r_cyc    <= 1'b0;
            r_len    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_vc <= i_cfg_wdata;
            end
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (o_result.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_item.valid) begin
                        if (i_item.cmd == CMD_LOAD) begin
                            if (r_etot == CW'(MAX_E) || {1'b0, i_item.src_vertex} >= w_n ||
                                {1'b0, i_item.dst_vertex} >= w_n) begin
                                r_drop <= 1'b1;
                            end else begin
                                r_esrc[r_etot[VW-1:0]] <= i_item.src_vertex;
                                r_edst[r_etot[VW-1:0]] <= i_item.dst_vertex;
                                r_ew[r_etot[VW-1:0]]   <= i_item.weight;
                                r_etot <= r_etot + CW'(1);
                            end
                        end else begin
                            for (int u = 0; u < MAX_V; u++) begin
                                r_indeg[u] <= '0;
                                r_earl[u]  <= '0;
                            end
                            r_k    <= '0;
                            r_head <= '0;
                            r_tail <= '0;
                            r_cyc  <= 1'b0;
                            r_len  <= '0;
                            r_state <= S_DEG;
                        end
                    end
                end
                // count in-degrees
                S_DEG: begin
                    if (e_end) begin
                        r_cnt   <= '0;
                        r_state <= S_SEED;
                    end else begin
                        if ({1'b0, e_src} < w_n && v_ok) begin
                            r_indeg[e_dst] <= r_indeg[e_dst] + CW'(1);
                        end
                        r_k <= r_k + CW'(1);
                    end
                end
                // queue every source vertex
                S_SEED: begin
                    if (r_cnt == w_n) begin
                        r_state <= S_POP;
                    end else begin
                        if (r_indeg[r_cnt[VW-1:0]] == '0) begin
                            r_topo[r_tail[VW-1:0]] <= r_cnt[VW-1:0];
                            r_tail <= r_tail + CW'(1);
                        end
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_POP: begin
                    if (r_head < r_tail) begin
                        r_vx    <= r_topo[r_head[VW-1:0]];
                        r_eu    <= r_earl[r_topo[r_head[VW-1:0]]];
                        r_head  <= r_head + CW'(1);
                        r_k     <= '0;
                        r_state <= S_RELAX;
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                // relax out-edges of the popped vertex
                S_RELAX: begin
                    if (e_end) begin
                        r_state <= S_POP;
                    end else begin
                        if (e_src == r_vx && v_ok) begin
                            r_indeg[e_dst] <= r_indeg[e_dst] - CW'(1);
                            if (r_indeg[e_dst] == CW'(1) && r_tail < CW'(MAX_V)) begin
                                r_topo[r_tail[VW-1:0]] <= e_dst;
                                r_tail <= r_tail + CW'(1);
                            end
                            if (alu_rsp.gt) begin
                                r_earl[e_dst] <= alu_rsp.res[TW-1:0];
                            end
                        end
                        r_k <= r_k + CW'(1);
                    end
                end
                S_CHK: begin
                    r_cnt <= '0;
                    if (r_tail < w_n) begin
                        r_cyc   <= 1'b1;
                        r_state <= S_SUM;
                    end else begin
                        r_state <= S_MAX;
                    end
                end
                // project length, then seed latest times
                S_MAX: begin
                    if (r_cnt == w_n) begin
                        for (int u = 0; u < MAX_V; u++) begin
                            r_late[u] <= r_len;
                        end
                        r_i     <= r_tail;
                        r_state <= S_BPOP;
                    end else begin
                        if (alu_rsp.gt) begin
                            r_len <= r_earl[r_cnt[VW-1:0]];
                        end
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_BPOP: begin
                    if (r_i == '0) begin
                        r_cnt   <= '0;
                        r_k     <= '0;
                        r_state <= S_CRIT;
                    end else begin
                        r_vx    <= topo_back;
                        r_lu    <= r_late[topo_back];
                        r_i     <= r_i - CW'(1);
                        r_k     <= '0;
                        r_state <= S_BEDGE;
                    end
                end
                // minimum over successors
                S_BEDGE: begin
                    if (e_end) begin
                        r_late[r_vx] <= r_lu;
                        r_state      <= S_BPOP;
                    end else begin
                        if (e_src == r_vx && v_ok && alu_rsp.lt) begin
                            r_lu <= alu_rsp.res[TW-1:0];
                        end
                        r_k <= r_k + CW'(1);
                    end
                end
                // report zero-slack edges in vertex, then store order
                S_CRIT: begin
                    if (r_cnt == w_n) begin
                        r_state <= S_SUM;
                    end else if (e_end) begin
                        r_cnt <= r_cnt + CW'(1);
                        r_k   <= '0;
                    end else if (e_src == r_cnt[VW-1:0] && v_ok && alu_rsp.eq) begin
                        if (out_free) begin
                            r_oedge  <= 1'b1;
                            r_ofrom  <= e_src;
                            r_oto    <= e_dst;
                            r_olen   <= '0;
                            r_ocyc   <= 1'b0;
                            r_oovf   <= 1'b0;
                            r_olast  <= 1'b0;
                            r_k      <= r_k + CW'(1);
                        end
                    end else begin
                        r_k <= r_k + CW'(1);
                    end
                end
                S_SUM: begin
                    if (out_free) begin
                        r_oedge  <= 1'b0;
                        r_ofrom  <= '0;
                        r_oto    <= '0;
                        r_olen   <= r_cyc ? '0 : r_len;
                        r_ocyc   <= r_cyc;
                        r_oovf   <= r_drop;
                        r_olast  <= 1'b1;
                        r_etot   <= '0;
                        r_drop   <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result.valid       = r_ovalid;
    assign o_result.is_edge     = r_oedge;
    assign o_result.edge_from   = r_ofrom;
    assign o_result.edge_to     = r_oto;
    assign o_result.path_length = r_olen;
    assign o_result.cyclic      = r_ocyc;
    assign o_result.overflow    = r_oovf;
    assign o_result.last        = r_olast;

    `DCP_ASSERT_IMP(a_queue_order, 1'b1, r_head <= r_tail && r_tail <= CW'(MAX_V), "queue pointers out of order")
    `DCP_ASSERT_IMP(a_store_bound, 1'b1, r_etot <= CW'(MAX_E), "edge count past store size")
    `DCP_ASSERT_NXT(a_sum_clears, r_state == S_SUM && out_free, r_etot == '0 && !r_drop && r_ovalid && r_olast, "summary did not close run")
    `DCP_ASSERT_IMP(a_crit_acyclic, r_state == S_CRIT, !r_cyc && r_cnt <= w_n, "edge scan on cyclic graph")

endmodule
